[rtl/lom_pkg.sv]
// Shared types and constants for the limit order matcher.
// Holds the word formats, the book entry layout, the memory request and the sequencer states.
// No dependencies.
package lom_pkg;

	localparam int BOOK_DEPTH = 16;
	localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

	localparam logic [1:0] KIND_FILL   = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic MODE_NEW    = 1'b0;
	localparam logic MODE_CANCEL = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;

	typedef struct packed {
		logic        mode;
		logic [8:0]  trader_no;
		logic [30:0] order_no;
		logic        side;
		logic [19:0] price;
		logic [15:0] quantity;
	} order_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [8:0]  out_trader;
		logic [30:0] out_order;
		logic        out_side;
		logic [19:0] out_price;
		logic [15:0] out_quantity;
		logic [15:0] filled_amount;
		logic        last;
	} result_word_t;

	typedef struct packed {
		logic [30:0] order_no;
		logic [8:0]  trader_no;
		logic        side;
		logic [19:0] price;
		logic [15:0] remaining;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} ram_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_AGG,
		ST_REST,
		ST_ACK,
		ST_FINISH,
		ST_REJ,
		ST_FLUSH
	} seq_state_t;

endpackage

[rtl/lom_book_ram.sv]
// Book entry memory: one write port and one read port with registered read data.
// Depends on lom_pkg for the entry layout and the request struct.
module lom_book_ram
	import lom_pkg::*;
(
	input  logic     clk,
	input  ram_req_t req,
	output entry_t   rd_data
);

	entry_t mem [BOOK_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/lom_seq.sv]
// Matching sequencer: scans the book memory slot by slot, builds fills, acks and rejects.
// Keeps the slot valid bits and holds back one result until it is known whether it is the last.
// Depends on lom_pkg.
module lom_seq
	import lom_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         order_valid,
	output logic         order_stall,
	input  order_word_t  order_word,
	output ram_req_t     ram_req,
	input  entry_t       rd_data,
	input  logic         out_rdy,
	output logic         push,
	output result_word_t push_word
);

	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [15:0]      left_q, left_d;
	order_word_t      item_q, item_d;
	logic [BOOK_DEPTH-1:0] valid_q, valid_d;
	logic             pend_valid_q, pend_valid_d;
	result_word_t     pend_q, pend_d;

	logic [IDX_W-1:0] slot;
	logic             crosses;
	logic             opposite;
	logic [15:0]      take;
	logic [IDX_W-1:0] free_idx;
	logic             free_any;
	logic             gen;
	result_word_t     gen_word;
	logic             scan_done;

	assign slot = idx_q[IDX_W-1:0];
	assign opposite = rd_data.side != item_q.side;
	assign crosses = (item_q.side == SIDE_BUY) ? (item_q.price >= rd_data.price)
		: (item_q.price <= rd_data.price);
	assign take = (left_q < rd_data.remaining) ? left_q : rd_data.remaining;
	assign free_any = ~&valid_q;
	assign scan_done = (idx_q == CNT_W'(BOOK_DEPTH))
		|| ((item_q.mode == MODE_NEW) && (left_q == 16'd0));
	assign order_stall = state_q != ST_IDLE;

	always_comb begin
		free_idx = '0;
		for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			valid_q      <= valid_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		left_q <= left_d;
		item_q <= item_d;
		pend_q <= pend_d;
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		left_d       = left_q;
		item_d       = item_q;
		valid_d      = valid_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		ram_req      = '0;
		gen          = 1'b0;
		gen_word     = '0;
		push         = 1'b0;
		push_word    = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (order_valid) begin
					item_d = order_word;
					idx_d  = '0;
					left_d = order_word.quantity;
					if (order_word.mode == MODE_CANCEL || order_word.quantity != 16'd0) begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				if (scan_done) begin
					state_d = ST_FINISH;
				end else if (!valid_q[slot]) begin
					idx_d = idx_q + CNT_W'(1);
				end else begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = slot;
					state_d         = ST_EV;
				end
			end
			ST_EV: begin
				if (item_q.mode == MODE_CANCEL) begin
					if (rd_data.order_no == item_q.order_no) begin
						state_d = ST_ACK;
					end else begin
						idx_d   = idx_q + CNT_W'(1);
						state_d = ST_RD;
					end
				end else if (opposite && crosses) begin
					state_d = ST_AGG;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_RD;
				end
			end
			ST_AGG: begin
				if (out_rdy) begin
					gen      = 1'b1;
					gen_word = '{KIND_FILL, item_q.trader_no, item_q.order_no, item_q.side,
						rd_data.price, item_q.quantity, take, 1'b0};
					state_d  = ST_REST;
				end
			end
			ST_REST: begin
				if (out_rdy) begin
					gen      = 1'b1;
					gen_word = '{KIND_FILL, rd_data.trader_no, rd_data.order_no, rd_data.side,
						rd_data.price, rd_data.remaining, take, 1'b0};
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = slot;
					ram_req.wr_data = rd_data;
					ram_req.wr_data.remaining = rd_data.remaining - take;
					if (rd_data.remaining == take) begin
						valid_d[slot] = 1'b0;
					end
					left_d  = left_q - take;
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_RD;
				end
			end
			ST_ACK: begin
				if (out_rdy) begin
					gen      = 1'b1;
					gen_word = '{KIND_ACK, item_q.trader_no, item_q.order_no, item_q.side,
						item_q.price, rd_data.remaining, 16'd0, 1'b0};
					valid_d[slot] = 1'b0;
					state_d  = ST_FLUSH;
				end
			end
			ST_FINISH: begin
				if (item_q.mode == MODE_CANCEL) begin
					state_d = ST_REJ;
				end else if (left_q == 16'd0) begin
					state_d = ST_FLUSH;
				end else if (free_any) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = free_idx;
					ram_req.wr_data = '{item_q.order_no, item_q.trader_no, item_q.side,
						item_q.price, left_q};
					valid_d[free_idx] = 1'b1;
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_REJ;
				end
			end
			ST_REJ: begin
				if (out_rdy) begin
					gen      = 1'b1;
					gen_word = '{KIND_REJECT, item_q.trader_no, item_q.order_no, item_q.side,
						item_q.price, left_q, 16'd0, 1'b0};
					state_d  = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_rdy) begin
					push           = 1'b1;
					push_word.last = 1'b1;
					pend_valid_d   = 1'b0;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (gen) begin
			push         = pend_valid_q;
			pend_d       = gen_word;
			pend_valid_d = 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> out_rdy)
		else $error("Result pushed while the output register is full.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
		else $error("Book memory read and written at the same entry.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REST || state_q == ST_ACK) |-> valid_q[slot])
		else $error("Trade or cancel on a slot that is not occupied.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && $past(state_q) != ST_IDLE) |-> (left_q <= $past(left_q)))
		else $error("Open quantity grew during an order.");

endmodule

[rtl/limit_order_matcher.sv]
// Limit order matcher top level: sequencer, book memory and the result output register.
// Depends on lom_pkg, lom_book_ram and lom_seq.
// A zero-quantity new order ends when its word is taken. Otherwise the sequencer walks the slots,
// skips empty ones, reads and evaluates each occupied one and emits two fills per trade; then it
// rests the remainder or rejects the order, and a cancel is answered with an ack or a reject.
// Reset clears the slot valid bits at once; no clearing pass runs and words are taken right after.
module limit_order_matcher
	import lom_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         order_valid,
	output logic         order_stall,
	input  order_word_t  order_word,
	output logic         result_valid,
	input  logic         result_stall,
	output result_word_t result_word
);

	ram_req_t     ram_req;
	entry_t       rd_data;
	logic         out_rdy;
	logic         push;
	result_word_t push_word;
	logic         result_valid_q;
	result_word_t result_word_q;

	assign out_rdy = !result_valid_q || !result_stall;

	lom_book_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	lom_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.order_valid (order_valid),
		.order_stall (order_stall),
		.order_word  (order_word),
		.ram_req     (ram_req),
		.rd_data     (rd_data),
		.out_rdy     (out_rdy),
		.push        (push),
		.push_word   (push_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_rdy) begin
			result_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && push) begin
			result_word_q <= push_word;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_word_q;

endmodule
